FILE: rtl/core/rar_pkg.sv
// ----------------------------------------------------------------------------
// rar_pkg
// shared types and constants for the rational arithmetic reducer
// ----------------------------------------------------------------------------
`default_nettype none
package rar_pkg;

  localparam int RES_W = 33;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture operands, start products
    logic form;       // build intermediates from products
    logic div_start;  // start one divide
    logic div_sel;    // 0: euclid step x%y, 1: final n/g or d/g
    logic div_den;    // final divide of d instead of n
    logic step;       // x <= y, y <= remainder
    logic keep_n;     // store n/g
    logic keep_d;     // store d/g
    logic out_load;   // latch result into output register
  } rar_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic y_zero;
    logic x_zero;
    logic div_done;
  } rar_sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/rar_div.sv
// ----------------------------------------------------------------------------
// rar_div
// signed truncating divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module rar_div #(
  parameter int W = 34
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quot,
  output logic [W-1:0]      rem
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic          qneg_r, qneg_nxt, rneg_r, rneg_nxt;
  logic [W:0]    trial;
  logic [W-1:0]  rsh;

  always_comb begin
    q_nxt = q_r; r_nxt = r_r; d_nxt = d_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0; qneg_nxt = qneg_r; rneg_nxt = rneg_r;
    rsh = {r_r[W-2:0], q_r[W-1]};
    trial = {1'b0, rsh} - {1'b0, d_r};
    if (start) begin
      q_nxt = dividend[W-1] ? -dividend : dividend;
      d_nxt = divisor[W-1] ? -divisor : divisor;
      r_nxt = '0;
      cnt_nxt = CW'(W);
      busy_nxt = 1'b1;
      qneg_nxt = dividend[W-1] ^ divisor[W-1];
      rneg_nxt = dividend[W-1];
    end else if (busy_r) begin
      if (!trial[W]) begin
        r_nxt = trial[W-1:0];
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        r_nxt = rsh;
        q_nxt = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt; r_r <= r_nxt; d_r <= d_nxt;
    qneg_r <= qneg_nxt; rneg_r <= rneg_nxt;
  end

  assign done = done_r;
  assign quot = qneg_r ? -q_r : q_r;
  assign rem  = rneg_r ? -r_r : r_r;
endmodule
`default_nettype wire

FILE: rtl/core/rar_dp.sv
// ----------------------------------------------------------------------------
// rar_dp
// datapath: cross products, euclid registers, shared divider, result
// ----------------------------------------------------------------------------
`default_nettype none
module rar_dp #(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire rar_pkg::rar_cmd_t           cmd,
  output rar_pkg::rar_sts_t                sts,
  input  wire logic [1:0]                  in_operation,
  input  wire logic signed [OPERAND_WIDTH-1:0] in_a_num,
  input  wire logic signed [OPERAND_WIDTH-1:0] in_a_den,
  input  wire logic signed [OPERAND_WIDTH-1:0] in_b_num,
  input  wire logic signed [OPERAND_WIDTH-1:0] in_b_den,
  output logic signed [rar_pkg::RES_W-1:0] out_res_num,
  output logic signed [rar_pkg::RES_W-1:0] out_res_den,
  output logic                             out_zero_gcd_error
);
  localparam int PW = 2 * OPERAND_WIDTH;
  localparam int IW = PW + 1;
  localparam int DW = IW + 1;

  logic [1:0]           op_r;
  logic signed [PW-1:0] p0_r, p1_r, p2_r, p3_r;
  logic signed [IW-1:0] n_r, d_r, x_r, y_r, nq_r, dq_r;
  logic signed [IW-1:0] n_nxt, d_nxt;
  logic                 ddone;
  logic [DW-1:0]        quot, rem, dvd, dvs;

  // multiply and divide need different product pairs
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_operation;
      p0_r <= PW'(in_a_num) * PW'(in_b_num);
      p1_r <= PW'(in_a_num) * PW'(in_b_den);
      p2_r <= (in_operation == rar_pkg::OP_DIV) ? PW'(in_a_den) * PW'(in_b_num)
                                                : PW'(in_a_den) * PW'(in_b_den);
      // add/sub need bn*ad
      p3_r <= PW'(in_b_num) * PW'(in_a_den);
    end
  end

  always_comb begin
    d_nxt = IW'(p2_r);
    case (op_r)
      rar_pkg::OP_ADD: n_nxt = IW'(p1_r) + IW'(p3_r);
      rar_pkg::OP_SUB: n_nxt = IW'(p1_r) - IW'(p3_r);
      rar_pkg::OP_MUL: n_nxt = IW'(p0_r);
      default:         n_nxt = IW'(p1_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.form) begin
      n_r <= n_nxt;
      d_r <= d_nxt;
      x_r <= n_nxt;
      y_r <= d_nxt;
    end else if (cmd.step) begin
      x_r <= y_r;
      y_r <= IW'(rem);
    end
    if (cmd.keep_n) nq_r <= IW'(quot);
    if (cmd.keep_d) dq_r <= IW'(quot);
  end

  assign dvd = !cmd.div_sel ? DW'(x_r) : (cmd.div_den ? DW'(d_r) : DW'(n_r));
  assign dvs = !cmd.div_sel ? DW'(y_r) : DW'(x_r);

  rar_div #(.W(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .dividend(dvd), .divisor(dvs), .done(ddone), .quot(quot), .rem(rem)
  );

  assign sts.y_zero   = (y_r == '0);
  assign sts.x_zero   = (x_r == '0);
  assign sts.div_done = ddone;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_zero_gcd_error <= (x_r == '0);
      out_res_num <= (x_r == '0) ? '0 : rar_pkg::RES_W'(nq_r);
      out_res_den <= (x_r == '0) ? '0 : rar_pkg::RES_W'(dq_r);
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/rar_ctrl.sv
// ----------------------------------------------------------------------------
// rar_ctrl
// sequencer for load, euclid loop, final divides and result handshake
// ----------------------------------------------------------------------------
`default_nettype none
module rar_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output rar_pkg::rar_cmd_t      cmd,
  input  wire rar_pkg::rar_sts_t sts
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FORM = 3'd1;
  localparam logic [2:0] S_TEST = 3'd2;
  localparam logic [2:0] S_EUC  = 3'd3;
  localparam logic [2:0] S_DN   = 3'd4;
  localparam logic [2:0] S_DD   = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] st_r, st_nxt;
  logic       ov_r, ov_nxt;

  // idle takes the next beat while the last result may still wait
  assign in_ready  = (st_r == S_IDLE);
  assign out_valid = ov_r;

  always_comb begin
    cmd = '0;
    st_nxt = st_r; ov_nxt = ov_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (st_r)
      S_IDLE: if (in_valid) begin cmd.load = 1'b1; st_nxt = S_FORM; end
      S_FORM: begin cmd.form = 1'b1; st_nxt = S_TEST; end
      S_TEST: begin
        if (!sts.y_zero) begin
          cmd.div_start = 1'b1; st_nxt = S_EUC;
        end else if (sts.x_zero) begin
          st_nxt = S_OUT;
        end else begin
          cmd.div_start = 1'b1; cmd.div_sel = 1'b1; st_nxt = S_DN;
        end
      end
      S_EUC: if (sts.div_done) begin cmd.step = 1'b1; st_nxt = S_TEST; end
      S_DN: begin
        cmd.div_sel = 1'b1;
        if (sts.div_done) begin
          cmd.keep_n = 1'b1; cmd.div_start = 1'b1; cmd.div_den = 1'b1;
          st_nxt = S_DD;
        end
      end
      S_DD: begin
        cmd.div_sel = 1'b1; cmd.div_den = 1'b1;
        if (sts.div_done) begin cmd.keep_d = 1'b1; st_nxt = S_OUT; end
      end
      S_OUT: if (!ov_r || out_ready) begin
        cmd.out_load = 1'b1; ov_nxt = 1'b1; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/rational_arith_reduce.sv
// ----------------------------------------------------------------------------
// rational_arith_reduce
// fraction add/sub/mul/div with euclid gcd reduction of the result
// ----------------------------------------------------------------------------
// usage:
//   input beat: in_operation and four signed operands on in_valid/in_ready.
//   result beat: out_res_num, out_res_den, out_zero_gcd_error on
//   out_valid/out_ready. one result per input beat, in order.
//   steps: the intermediates are formed, then each euclid step runs one
//   divide through the shared bit-serial divider, then two final divides
//   run and the result is loaded. worst case around 47 euclid steps at
//   the default width. the single divider sets the rate.
//   one item is in work at a time; a new beat is taken once the result is
//   in the output register, even if the receiver has not taken it yet.
//   if the receiver stalls, the finished result holds until it is taken.
//   reset (rst_n low, synchronous) drops out_valid and returns to idle.
//   gcd of zero gives 0/0 with out_zero_gcd_error set.
// ----------------------------------------------------------------------------
`default_nettype none
module rational_arith_reduce #(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      in_operation,
  input  wire logic signed [OPERAND_WIDTH-1:0] in_a_num,
  input  wire logic signed [OPERAND_WIDTH-1:0] in_a_den,
  input  wire logic signed [OPERAND_WIDTH-1:0] in_b_num,
  input  wire logic signed [OPERAND_WIDTH-1:0] in_b_den,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [rar_pkg::RES_W-1:0]     out_res_num,
  output logic signed [rar_pkg::RES_W-1:0]     out_res_den,
  output logic                                 out_zero_gcd_error
);
  rar_pkg::rar_cmd_t cmd;
  rar_pkg::rar_sts_t sts;

  rar_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
  );

  rar_dp #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_operation(in_operation), .in_a_num(in_a_num), .in_a_den(in_a_den),
    .in_b_num(in_b_num), .in_b_den(in_b_den),
    .out_res_num(out_res_num), .out_res_den(out_res_den),
    .out_zero_gcd_error(out_zero_gcd_error)
  );
endmodule
`default_nettype wire

FILE: dv/rar_checker.sv
// ----------------------------------------------------------------------------
// rar_checker
// watches both channels of the rational reducer, predicts each reduced
// fraction from the input beat and compares it with the result beat in order
// ----------------------------------------------------------------------------
module rar_checker #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic [1:0]                           in_operation,
  input  logic signed [OPERAND_WIDTH-1:0]      in_a_num,
  input  logic signed [OPERAND_WIDTH-1:0]      in_a_den,
  input  logic signed [OPERAND_WIDTH-1:0]      in_b_num,
  input  logic signed [OPERAND_WIDTH-1:0]      in_b_den,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic signed [rar_pkg::RES_W-1:0]     out_res_num,
  input  logic signed [rar_pkg::RES_W-1:0]     out_res_den,
  input  logic                                 out_zero_gcd_error,
  output int                                   fail_count,
  output int                                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [rar_pkg::RES_W-1:0] num;
    logic signed [rar_pkg::RES_W-1:0] den;
    logic                             zero_err;
  } frac_t;

  frac_t reduced_q[$];

  function automatic frac_t reduce_frac(logic [1:0] op, longint an, longint ad,
                                        longint bn, longint bd);
    longint n, d, x, y, r;
    frac_t f;
    case (op)
      rar_pkg::OP_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
      rar_pkg::OP_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
      rar_pkg::OP_MUL: begin n = an * bn; d = ad * bd; end
      default: begin n = an * bd; d = ad * bn; end
    endcase
    x = n;
    y = d;
    // truncating remainder, gcd may come out negative
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    if (x == 0) begin
      f.num = '0;
      f.den = '0;
      f.zero_err = 1'b1;
    end else begin
      f.num = rar_pkg::RES_W'(n / x);
      f.den = rar_pkg::RES_W'(d / x);
      f.zero_err = 1'b0;
    end
    return f;
  endfunction

  initial fail_count = 0;

  always @(posedge clk) begin
    frac_t exp_f;
    if (rst_n && in_valid && in_ready)
      reduced_q.push_back(reduce_frac(in_operation, longint'(in_a_num),
        longint'(in_a_den), longint'(in_b_num), longint'(in_b_den)));
    if (rst_n && out_valid && out_ready) begin
      if (reduced_q.size() == 0) begin
        fail_count <= fail_count + 1;
        if (fail_count < 10) $display("unexpected result beat %0d/%0d",
          out_res_num, out_res_den);
      end else begin
        exp_f = reduced_q.pop_front();
        if (exp_f.num !== out_res_num || exp_f.den !== out_res_den ||
            exp_f.zero_err !== out_zero_gcd_error) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("mismatch: exp %0d/%0d err %0b, got %0d/%0d err %0b",
              exp_f.num, exp_f.den, exp_f.zero_err,
              out_res_num, out_res_den, out_zero_gcd_error);
        end
      end
    end
    pending <= reduced_q.size();
  end

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// drives directed and random fraction beats into the reducer with random
// gaps and receiver stalls, and reports the checker's verdict
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OW = 16;
  localparam int N_RANDOM = 300;
  localparam longint MAX_CYCLES = 4000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_operation = rar_pkg::OP_ADD;
  logic signed [OW-1:0] in_a_num = '0, in_a_den = '0, in_b_num = '0, in_b_den = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [rar_pkg::RES_W-1:0] out_res_num, out_res_den;
  logic out_zero_gcd_error;
  int fail_count, pending;
  longint cycles = 0;
  bit hold_off = 1'b0;

  always #6 clk = ~clk;

  rational_arith_reduce #(.OPERAND_WIDTH(OW)) u_top (.*);

  rar_checker #(.OPERAND_WIDTH(OW)) u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [OW-1:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return ($urandom_range(0, 1) != 0) ? {1'b1, {(OW-1){1'b0}}}
                                            : {1'b0, {(OW-1){1'b1}}};
      1: return OW'($urandom_range(0, 4)) - OW'(2);
      2: return OW'($urandom_range(0, 60));
      default: return OW'($urandom);
    endcase
  endfunction

  // valid stays up into the next beat unless a gap follows
  task automatic send_beat(logic [1:0] op, logic [OW-1:0] an, logic [OW-1:0] ad,
                           logic [OW-1:0] bn, logic [OW-1:0] bd);
    in_operation <= op;
    in_a_num <= an;
    in_a_den <= ad;
    in_b_num <= bn;
    in_b_den <= bd;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(20, 300) : $urandom_range(1, 3))
        @(negedge clk);
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_off)
      out_ready <= 1'b0;
    else if ($urandom_range(0, 9) < 6)
      out_ready <= 1'b1;
    else
      out_ready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 1) == 1);
  end

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed: each op, extremes, zero cases
    for (int op = 0; op < 4; op++) begin
      send_beat(op[1:0], 16'sd1, 16'sd2, 16'sd1, 16'sd3);
      send_beat(op[1:0], 16'h8000, 16'h8000, 16'h7fff, 16'h8000);
      send_beat(op[1:0], 16'hffff, 16'h7fff, 16'h8000, 16'hffff);
    end
    send_beat(rar_pkg::OP_ADD, 16'sd0, 16'sd5, 16'sd0, 16'sd7);   // 0 numerator
    send_beat(rar_pkg::OP_MUL, 16'sd3, 16'sd0, 16'sd4, 16'sd5);   // 0 denominator
    send_beat(rar_pkg::OP_MUL, 16'sd0, 16'sd0, 16'sd0, 16'sd0);   // zero gcd
    send_beat(rar_pkg::OP_SUB, 16'sd2, 16'sd3, 16'sd2, 16'sd3);   // zero numerator
    send_beat(rar_pkg::OP_DIV, 16'sd5, 16'sd3, 16'sd0, 16'sd4);   // divide by zero
    send_beat(rar_pkg::OP_DIV, 16'sd0, 16'sd3, 16'sd0, 16'sd4);   // 0/0
    send_beat(rar_pkg::OP_ADD, -16'sd6, 16'sd4, 16'sd9, -16'sd6); // negative gcd
    send_beat(rar_pkg::OP_ADD, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    // long receiver stall while the sender keeps going
    hold_off <= 1'b1;
    fork
      begin
        repeat (6000) @(negedge clk);
        hold_off <= 1'b0;
      end
      repeat (3) send_beat(rar_pkg::OP_MUL, rand_operand(), rand_operand(),
                           rand_operand(), rand_operand());
    join
    for (int i = 0; i < N_RANDOM; i++)
      send_beat(2'($urandom_range(0, 3)), rand_operand(), rand_operand(),
                rand_operand(), rand_operand());
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: rational_arith_reduce.f
rtl/core/rar_pkg.sv
rtl/core/rar_div.sv
rtl/core/rar_dp.sv
rtl/core/rar_ctrl.sv
rtl/core/rational_arith_reduce.sv
dv/rar_checker.sv
dv/tb.sv
